FILE: rtl/dnp_pkg.sv
// shared types for the decimal number text parser
// token classes passed from the front classifier to the back parser
package dnp_pkg;

    typedef enum logic [2:0] {
        TK_DIGIT,
        TK_PLUS,
        TK_MINUS,
        TK_POINT,
        TK_EXP,
        TK_OTHER,
        TK_END
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t  kind;
        logic [3:0] digit;
    } token_t;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_EXP   = 8'h45;

endpackage

FILE: rtl/dnp_front.sv
// front end: classifies each input character into a token and holds it
// in a two-entry queue for the back end; depends on dnp_pkg
module dnp_front import dnp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_character,
    input  logic       s_terminator,
    output logic       tok_valid,
    input  logic       tok_ready,
    output token_t     tok
);

    token_t     mem_reg [2];
    logic [1:0] count_reg, count_next;
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    token_t     cls;
    logic       push, pop;

    always_comb begin
        cls.digit = 4'(s_character - CH_ZERO);
        if (s_terminator) begin
            cls.kind = TK_END;
        end else if (s_character inside {[CH_ZERO:CH_NINE]}) begin
            cls.kind = TK_DIGIT;
        end else begin
            case (s_character)
                CH_PLUS:  cls.kind = TK_PLUS;
                CH_MINUS: cls.kind = TK_MINUS;
                CH_POINT: cls.kind = TK_POINT;
                CH_EXP:   cls.kind = TK_EXP;
                default:  cls.kind = TK_OTHER;
            endcase
        end
    end

    assign s_ready   = (count_reg != 2'd2);
    assign tok_valid = (count_reg != 2'd0);
    assign tok       = mem_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = tok_valid && tok_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
        if (!aresetn) begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

endmodule

FILE: rtl/dnp_back.sv
// back end: grammar state machine, digit accumulation with saturation and
// the output register for the result; depends on dnp_pkg
module dnp_back import dnp_pkg::*; #(
    parameter int MANTISSA_BITS = 64,
    parameter int EXPONENT_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            tok_valid,
    output logic                            tok_ready,
    input  token_t                          tok,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_negative,
    output logic [MANTISSA_BITS-1:0]        m_mantissa,
    output logic signed [EXPONENT_BITS-1:0] m_decimal_exponent,
    output logic                            m_valid_res,
    output logic                            m_overflow
);

    localparam int MW = MANTISSA_BITS;
    localparam int EW = EXPONENT_BITS;
    localparam logic [EW+3:0] EXP_LIM_X = {4'b0000, 1'b1, {(EW-1){1'b0}}};
    localparam logic [EW-1:0] EXP_LIM   = {1'b1, {(EW-1){1'b0}}};
    localparam logic signed [EW+1:0] E_MAX = {3'b000, {(EW-1){1'b1}}};
    localparam logic signed [EW+1:0] E_MIN = {3'b111, {(EW-1){1'b0}}};

    typedef enum logic [3:0] {
        ST_INIT, ST_SIGN, ST_INT, ST_POINT, ST_FRAC,
        ST_EXP, ST_EXPSIGN, ST_EXPDIG, ST_ERROR
    } state_t;

    state_t          state_reg, state_next;
    logic            minus_reg, minus_next;
    logic [MW-1:0]   acc_reg, acc_next;
    logic [EW-1:0]   frac_reg, frac_next;
    logic [EW-1:0]   expv_reg, expv_next;
    logic            expneg_reg, expneg_next;
    logic            sat_reg, sat_next;

    logic            m_valid_reg, m_valid_next;
    logic            neg_out_reg, neg_out_next;
    logic [MW-1:0]   mant_out_reg, mant_out_next;
    logic [EW-1:0]   exp_out_reg, exp_out_next;
    logic            ok_out_reg, ok_out_next;
    logic            ovf_out_reg, ovf_out_next;

    logic            out_free, tok_fire, is_end;
    logic [MW+3:0]   mant_step;
    logic            mant_ovf;
    logic [EW+3:0]   exp_step;
    logic            exp_ovf;
    logic signed [EW+1:0] e_signed, e_sum;
    logic            ok;

    assign out_free  = !m_valid_reg || m_ready;
    assign is_end    = (tok.kind == TK_END);
    assign tok_ready = !is_end || out_free;
    assign tok_fire  = tok_valid && tok_ready;

    // acc * 10 + d as shift-add, overflow when the top bits are set
    assign mant_step = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                     + {{MW{1'b0}}, tok.digit};
    assign mant_ovf  = |mant_step[MW+3:MW];
    assign exp_step  = {1'b0, expv_reg, 3'b000} + {3'b000, expv_reg, 1'b0}
                     + {{EW{1'b0}}, tok.digit};
    assign exp_ovf   = (exp_step > EXP_LIM_X);

    assign e_signed = expneg_reg ? -signed'({2'b00, expv_reg}) : signed'({2'b00, expv_reg});
    assign e_sum    = e_signed - signed'({2'b00, frac_reg});

    assign ok = (state_reg == ST_INIT) || (state_reg == ST_SIGN) || (state_reg == ST_INT) ||
                (state_reg == ST_POINT) || (state_reg == ST_FRAC) || (state_reg == ST_EXPDIG);

    always_comb begin
        state_next    = state_reg;
        minus_next    = minus_reg;
        acc_next      = acc_reg;
        frac_next     = frac_reg;
        expv_next     = expv_reg;
        expneg_next   = expneg_reg;
        sat_next      = sat_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        neg_out_next  = neg_out_reg;
        mant_out_next = mant_out_reg;
        exp_out_next  = exp_out_reg;
        ok_out_next   = ok_out_reg;
        ovf_out_next  = ovf_out_reg;

        if (tok_fire && is_end) begin
            m_valid_next  = 1'b1;
            neg_out_next  = 1'b0;
            mant_out_next = '0;
            exp_out_next  = '0;
            ok_out_next   = ok;
            ovf_out_next  = 1'b0;
            if (ok) begin
                neg_out_next  = minus_reg;
                mant_out_next = acc_reg;
                ovf_out_next  = sat_reg;
                if (e_sum > E_MAX) begin
                    exp_out_next = E_MAX[EW-1:0];
                    ovf_out_next = 1'b1;
                end else if (e_sum < E_MIN) begin
                    exp_out_next = E_MIN[EW-1:0];
                    ovf_out_next = 1'b1;
                end else begin
                    exp_out_next = e_sum[EW-1:0];
                end
            end
            state_next  = ST_INIT;
            minus_next  = 1'b0;
            acc_next    = '0;
            frac_next   = '0;
            expv_next   = '0;
            expneg_next = 1'b0;
            sat_next    = 1'b0;
        end else if (tok_fire) begin
            case (state_reg)
                ST_INIT: begin
                    if (tok.kind == TK_PLUS || tok.kind == TK_MINUS) begin
                        minus_next = (tok.kind == TK_MINUS);
                        state_next = ST_SIGN;
                    end else if (tok.kind == TK_DIGIT) begin
                        acc_next   = mant_ovf ? '1 : mant_step[MW-1:0];
                        sat_next   = sat_reg || mant_ovf;
                        state_next = ST_INT;
                    end else if (tok.kind == TK_POINT) begin
                        state_next = ST_POINT;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                ST_SIGN: begin
                    if (tok.kind == TK_DIGIT) begin
                        acc_next   = mant_ovf ? '1 : mant_step[MW-1:0];
                        sat_next   = sat_reg || mant_ovf;
                        state_next = ST_INT;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                ST_INT: begin
                    if (tok.kind == TK_DIGIT) begin
                        acc_next = mant_ovf ? '1 : mant_step[MW-1:0];
                        sat_next = sat_reg || mant_ovf;
                    end else if (tok.kind == TK_POINT) begin
                        state_next = ST_POINT;
                    end else if (tok.kind == TK_EXP) begin
                        state_next = ST_EXP;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                ST_POINT, ST_FRAC: begin
                    if (tok.kind == TK_DIGIT) begin
                        acc_next = mant_ovf ? '1 : mant_step[MW-1:0];
                        // fraction count stops at the exponent limit
                        if (frac_reg[EW-1]) begin
                            sat_next = 1'b1;
                        end else begin
                            frac_next = frac_reg + 1'b1;
                            sat_next  = sat_reg || mant_ovf;
                        end
                        state_next = ST_FRAC;
                    end else if (tok.kind == TK_EXP) begin
                        state_next = ST_EXP;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                ST_EXP: begin
                    if (tok.kind == TK_PLUS || tok.kind == TK_MINUS) begin
                        expneg_next = (tok.kind == TK_MINUS);
                        state_next  = ST_EXPSIGN;
                    end else if (tok.kind == TK_DIGIT) begin
                        expv_next  = exp_ovf ? EXP_LIM : exp_step[EW-1:0];
                        sat_next   = sat_reg || exp_ovf;
                        state_next = ST_EXPDIG;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                ST_EXPSIGN, ST_EXPDIG: begin
                    if (tok.kind == TK_DIGIT) begin
                        expv_next  = exp_ovf ? EXP_LIM : exp_step[EW-1:0];
                        sat_next   = sat_reg || exp_ovf;
                        state_next = ST_EXPDIG;
                    end else begin
                        state_next = ST_ERROR;
                    end
                end
                default: begin
                    state_next = ST_ERROR;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        neg_out_reg  <= neg_out_next;
        mant_out_reg <= mant_out_next;
        exp_out_reg  <= exp_out_next;
        ok_out_reg   <= ok_out_next;
        ovf_out_reg  <= ovf_out_next;
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            minus_reg   <= 1'b0;
            acc_reg     <= '0;
            frac_reg    <= '0;
            expv_reg    <= '0;
            expneg_reg  <= 1'b0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            minus_reg   <= minus_next;
            acc_reg     <= acc_next;
            frac_reg    <= frac_next;
            expv_reg    <= expv_next;
            expneg_reg  <= expneg_next;
            sat_reg     <= sat_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_negative         = neg_out_reg;
    assign m_mantissa         = mant_out_reg;
    assign m_decimal_exponent = signed'(exp_out_reg);
    assign m_valid_res        = ok_out_reg;
    assign m_overflow         = ovf_out_reg;

endmodule

FILE: rtl/decimal_number_text_parser.sv
// top level of the decimal number text parser: front classifier and queue,
// back parser and output register; depends on dnp_pkg, dnp_front, dnp_back
//
//  channel  | ports                                   | carries
//  ---------+-----------------------------------------+-----------------------------
//  input    | s_valid s_ready s_character s_terminator | one character or end marker
//  result   | m_valid m_ready m_negative m_mantissa    | one result per end marker
//           | m_decimal_exponent m_valid_res m_overflow|
//
// one character per cycle sustained while no result is stalled; the back end
// takes one token per cycle through a single shift-add of the digit accumulator
// a result is registered on m_valid when the back end takes its end marker
// reset: synchronous, active low on aresetn, no clearing pass
// while a result is stalled the next end marker waits at the queue head; characters
// behind it fill the two-entry queue and then s_ready drops
module decimal_number_text_parser import dnp_pkg::*; #(
    parameter int MANTISSA_BITS = 64,
    parameter int EXPONENT_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_character,
    input  logic                            s_terminator,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_negative,
    output logic [MANTISSA_BITS-1:0]        m_mantissa,
    output logic signed [EXPONENT_BITS-1:0] m_decimal_exponent,
    output logic                            m_valid_res,
    output logic                            m_overflow
);

    logic   tok_valid;
    logic   tok_ready;
    token_t tok;

    dnp_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_character  (s_character),
        .s_terminator (s_terminator),
        .tok_valid    (tok_valid),
        .tok_ready    (tok_ready),
        .tok          (tok)
    );

    dnp_back #(
        .MANTISSA_BITS (MANTISSA_BITS),
        .EXPONENT_BITS (EXPONENT_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .tok_valid          (tok_valid),
        .tok_ready          (tok_ready),
        .tok                (tok),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_negative         (m_negative),
        .m_mantissa         (m_mantissa),
        .m_decimal_exponent (m_decimal_exponent),
        .m_valid_res        (m_valid_res),
        .m_overflow         (m_overflow)
    );

endmodule

FILE: rtl/dnp_checker.sv
// port-level checks for the decimal number text parser
// attached to decimal_number_text_parser by the bind at the end of this file
module dnp_checker #(
    parameter int MANTISSA_BITS = 64,
    parameter int EXPONENT_BITS = 16
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [7:0]                      s_character,
    input logic                            s_terminator,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_negative,
    input logic [MANTISSA_BITS-1:0]        m_mantissa,
    input logic signed [EXPONENT_BITS-1:0] m_decimal_exponent,
    input logic                            m_valid_res,
    input logic                            m_overflow
);

    // a result waiting on the consumer stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result present after reset");

    // an error result carries all-zero fields
    a_error_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_valid_res |-> !m_negative && (m_mantissa == '0) &&
        (m_decimal_exponent == '0) && !m_overflow)
        else $error("error result with nonzero fields");

    // overflow is only reported on a well-formed string
    a_ovf_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_overflow |-> m_valid_res)
        else $error("overflow flagged on error result");

endmodule

bind decimal_number_text_parser dnp_checker #(
    .MANTISSA_BITS (MANTISSA_BITS),
    .EXPONENT_BITS (EXPONENT_BITS)
) u_dnp_checker (.*);
